// File: hdl/lcpr_pkg.sv
// ----------------------------------------------------------------------------
// lcpr_pkg: shared types and constants of the comet pool renderer
// Register indexes, item kinds, slot record, config record and chain token.
// ----------------------------------------------------------------------------
package lcpr_pkg;

    localparam int SLOTS = 12;
    localparam int SLOT_W = $clog2(SLOTS + 1);

    typedef enum logic [1:0] {
        KIND_START   = 2'd0,
        KIND_ADVANCE = 2'd1,
        KIND_QUERY   = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        REG_MOVE_INTERVAL = 3'd0,
        REG_STEP_SIZE     = 3'd1,
        REG_TAIL_LENGTH   = 3'd2,
        REG_LED_COUNT     = 3'd3,
        REG_BASE_SAT      = 3'd4,
        REG_SAT_DECAY     = 3'd5,
        REG_BASE_BRIGHT   = 3'd6,
        REG_BRIGHT_DECAY  = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic        active;
        logic [11:0] head;
        logic [9:0]  origin;
        logic        backward;
        logic [7:0]  hue;
        logic [31:0] last_move;
    } slot_t;

    typedef struct packed {
        logic [15:0] move_interval;
        logic [3:0]  step_size;
        logic [5:0]  tail_length;
        logic [9:0]  led_count;
        logic [7:0]  head_sat;
        logic [7:0]  sat_decay;
        logic [7:0]  base_bright;
        logic [7:0]  bright_decay;
    } cfg_t;

    // control word handed down the chain with each item
    typedef struct packed {
        logic        go;
        kind_t       kind;
        logic [31:0] now_ms;
        logic [9:0]  position;
        logic [7:0]  hue;
        logic [1:0]  want;      // starts still to place
        logic [1:0]  started;
        logic        lit;
        logic [7:0]  hue_out;
        logic [5:0]  k;
        logic [9:0]  origin;
    } token_t;

endpackage

// File: hdl/led_comet_pool_renderer.sv
// ----------------------------------------------------------------------------
// led_comet_pool_renderer: comet slot pool for an LED strip
// Start, advance and pixel query items against a chain of slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one request per item. s_tuser = kind; s_tdata = now_ms, position,
//     color_hue from bit 0 up (50 bits, padded to 56). One item in flight at a
//     time: s_tready is high only while the block is empty.
//   m_axis: exactly one result per request. m_tdata = pixel_hue,
//     pixel_saturation, pixel_brightness, started from bit 0 up; m_tuser = lit.
//   cfg: write channel, cfg_index selects the register, always ready.
// Path: the cell chain, one register per slot in slot order so the highest
//   covering slot wins, then the lcpr_shade color math and the output register.
// Items do not overlap: the next request is taken in the cycle after the
//   result is handed off.
// Reset (aresetn low, synchronous): all slots free, registers at defaults,
//   output empty. A stalled m_tready holds the result; the next request is
//   taken only after the result is delivered.
// ----------------------------------------------------------------------------
module led_comet_pool_renderer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // now_ms[31:0], position[41:32], color_hue[49:42]
    input  logic [1:0]  s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // pixel_hue, pixel_saturation, pixel_brightness, started
    output logic        m_tuser,   // lit
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    lcpr_pkg::cfg_t   cfg_reg;
    lcpr_pkg::token_t chain [lcpr_pkg::SLOTS + 1];
    logic busy_reg, mvalid_reg;
    logic [31:0] mdata_reg;
    logic mlit_reg;
    logic done, lit;
    logic [1:0] started;
    logic [7:0] ph, ps, pb;

    assign cfg_ready = 1'b1;
    assign s_tready  = !busy_reg;

    always_comb begin
        chain[0]          = '0;
        chain[0].go       = s_tvalid && !busy_reg;
        chain[0].kind     = lcpr_pkg::kind_t'(s_tuser);
        chain[0].now_ms   = s_tdata[31:0];
        chain[0].position = s_tdata[41:32];
        chain[0].hue      = s_tdata[49:42];
        chain[0].want     = (s_tuser == lcpr_pkg::KIND_START) ? 2'd2 : 2'd0;
    end

    for (genvar i = 0; i < lcpr_pkg::SLOTS; i++) begin : g_cell
        lcpr_cell u_cell (.aclk, .aresetn, .cfg(cfg_reg), .tok_in(chain[i]),
                          .tok_out(chain[i + 1]));
    end

    lcpr_shade u_shade (.aclk, .aresetn, .cfg(cfg_reg), .tok_in(chain[lcpr_pkg::SLOTS]),
                        .done, .started, .lit, .pixel_hue(ph), .pixel_sat(ps),
                        .pixel_bright(pb));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            mvalid_reg <= 1'b0;
            cfg_reg    <= '{16'd20, 4'd3, 6'd20, 10'd960, 8'd220, 8'd10, 8'd255, 8'd18};
        end else begin
            if (s_tvalid && s_tready) busy_reg <= 1'b1;
            if (done) begin
                mvalid_reg <= 1'b1;
                mdata_reg  <= {6'b0, started, pb, ps, ph};
                mlit_reg   <= lit;
            end else if (m_tready && mvalid_reg) begin
                mvalid_reg <= 1'b0;
                busy_reg   <= 1'b0;
            end
            if (cfg_valid) begin
                unique case (lcpr_pkg::reg_idx_t'(cfg_index))
                    lcpr_pkg::REG_MOVE_INTERVAL: cfg_reg.move_interval <= cfg_data;
                    lcpr_pkg::REG_STEP_SIZE:     cfg_reg.step_size     <= cfg_data[3:0];
                    lcpr_pkg::REG_TAIL_LENGTH:   cfg_reg.tail_length   <= cfg_data[5:0];
                    lcpr_pkg::REG_LED_COUNT:     cfg_reg.led_count     <= cfg_data[9:0];
                    lcpr_pkg::REG_BASE_SAT:      cfg_reg.head_sat      <= cfg_data[7:0];
                    lcpr_pkg::REG_SAT_DECAY:     cfg_reg.sat_decay     <= cfg_data[7:0];
                    lcpr_pkg::REG_BASE_BRIGHT:   cfg_reg.base_bright   <= cfg_data[7:0];
                    lcpr_pkg::REG_BRIGHT_DECAY:  cfg_reg.bright_decay  <= cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = mlit_reg;
endmodule

// File: hdl/lcpr_cell.sv
// ----------------------------------------------------------------------------
// lcpr_cell: one comet slot of the chain
// Holds one slot; updates it from the token passing by and forwards the token.
// ----------------------------------------------------------------------------
module lcpr_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  lcpr_pkg::cfg_t    cfg,
    input  lcpr_pkg::token_t  tok_in,
    output lcpr_pkg::token_t  tok_out
);
    lcpr_pkg::slot_t  slot_reg, slot_next;
    lcpr_pkg::token_t tok_reg, tok_next;
    logic [31:0] elapsed;
    logic signed [13:0] h, kq;

    always_comb begin
        slot_next = slot_reg;
        tok_next  = tok_in;
        elapsed   = tok_in.now_ms - slot_reg.last_move;
        h  = slot_reg.backward ? $signed({2'b0, slot_reg.head}) - $signed({10'b0, cfg.step_size})
                               : $signed({2'b0, slot_reg.head}) + $signed({10'b0, cfg.step_size});
        kq = slot_reg.backward ? $signed({4'b0, tok_in.position}) - $signed({2'b0, slot_reg.head})
                               : $signed({2'b0, slot_reg.head}) - $signed({4'b0, tok_in.position});
        if (tok_in.go) begin
            unique case (tok_in.kind)
                lcpr_pkg::KIND_START: begin
                    if (!slot_reg.active && tok_in.want != 2'd0) begin
                        slot_next.active    = 1'b1;
                        slot_next.head      = {2'b0, tok_in.position};
                        slot_next.origin    = tok_in.position;
                        slot_next.backward  = (tok_in.want == 2'd2);
                        slot_next.hue       = tok_in.hue;
                        slot_next.last_move = tok_in.now_ms;
                        tok_next.want       = tok_in.want - 2'd1;
                        tok_next.started    = tok_in.started + 2'd1;
                    end
                end
                lcpr_pkg::KIND_ADVANCE: begin
                    if (slot_reg.active && elapsed >= {16'b0, cfg.move_interval}) begin
                        slot_next.last_move = tok_in.now_ms;
                        if (h < 0 || h >= $signed({4'b0, cfg.led_count})) begin
                            slot_next.active = 1'b0;
                        end else begin
                            slot_next.head = h[11:0];
                        end
                    end
                end
                lcpr_pkg::KIND_QUERY: begin
                    if (slot_reg.active && tok_in.position < cfg.led_count && kq >= 0
                        && kq < $signed({8'b0, cfg.tail_length})) begin
                        tok_next.lit     = 1'b1;
                        tok_next.hue_out = slot_reg.hue;
                        tok_next.k       = kq[5:0];
                        tok_next.origin  = slot_reg.origin;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg.active <= 1'b0;
            tok_reg.go      <= 1'b0;
        end else begin
            slot_reg.active <= slot_next.active;
            tok_reg.go      <= tok_next.go;
        end
        slot_reg.head      <= slot_next.head;
        slot_reg.origin    <= slot_next.origin;
        slot_reg.backward  <= slot_next.backward;
        slot_reg.hue       <= slot_next.hue;
        slot_reg.last_move <= slot_next.last_move;
        tok_reg.kind     <= tok_next.kind;
        tok_reg.now_ms   <= tok_next.now_ms;
        tok_reg.position <= tok_next.position;
        tok_reg.hue      <= tok_next.hue;
        tok_reg.want     <= tok_next.want;
        tok_reg.started  <= tok_next.started;
        tok_reg.lit      <= tok_next.lit;
        tok_reg.hue_out  <= tok_next.hue_out;
        tok_reg.k        <= tok_next.k;
        tok_reg.origin   <= tok_next.origin;
    end

    assign tok_out = tok_reg;
endmodule

// File: hdl/lcpr_shade.sv
// ----------------------------------------------------------------------------
// lcpr_shade: tail color of the winning slot
// Noise hash and clamped decay, over three register stages.
// ----------------------------------------------------------------------------
module lcpr_shade (
    input  logic              aclk,
    input  logic              aresetn,
    input  lcpr_pkg::cfg_t    cfg,
    input  lcpr_pkg::token_t  tok_in,
    output logic              done,
    output logic [1:0]        started,
    output logic              lit,
    output logic [7:0]        pixel_hue,
    output logic [7:0]        pixel_sat,
    output logic [7:0]        pixel_bright
);
    logic [2:0]  go_reg;
    logic [31:0] v1_reg, v2_reg;
    logic [31:0] v0, vx;
    logic [5:0]  k1_reg, k2_reg;
    logic [1:0]  st1_reg, st2_reg, st3_reg;
    logic        lit1_reg, lit2_reg, lit3_reg;
    logic [7:0]  hue1_reg, hue2_reg, hue3_reg, sat3_reg, bri3_reg;
    logic [13:0] ks, kb;
    logic signed [15:0] sv, bv;
    logic [7:0]  n;

    assign v0 = 32'(tok_in.hue_out) * 32'd47 + 32'(tok_in.origin) * 32'd13
              + 32'(tok_in.k) * 32'd29;
    assign vx = v1_reg ^ (v1_reg >> 8);
    assign n  = v2_reg[7:0];
    assign ks = 14'(k2_reg) * 14'(cfg.sat_decay);
    assign kb = 14'(k2_reg) * 14'(cfg.bright_decay);
    assign sv = $signed({8'b0, cfg.head_sat}) - $signed({2'b0, ks}) - $signed({11'b0, n[4:0]});
    assign bv = $signed({8'b0, cfg.base_bright}) - $signed({2'b0, kb})
              - $signed({10'b0, n[5:0]});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            go_reg <= 3'b0;
        end else begin
            go_reg <= {go_reg[1:0], tok_in.go};
        end
        v1_reg <= v0; k1_reg <= tok_in.k; st1_reg <= tok_in.started;
        lit1_reg <= tok_in.lit; hue1_reg <= tok_in.hue_out;
        v2_reg <= vx * 32'd199873; k2_reg <= k1_reg; st2_reg <= st1_reg;
        lit2_reg <= lit1_reg; hue2_reg <= hue1_reg;
        st3_reg <= st2_reg; lit3_reg <= lit2_reg;
        hue3_reg <= lit2_reg ? hue2_reg : 8'd0;
        sat3_reg <= !lit2_reg ? 8'd0 : (sv < 16'sd20) ? 8'd20 : (sv > 16'sd255) ? 8'd255 : sv[7:0];
        bri3_reg <= !lit2_reg ? 8'd0 : (bv < 16'sd0) ? 8'd0 : (bv > 16'sd255) ? 8'd255 : bv[7:0];
    end

    assign done = go_reg[2];
    assign started = st3_reg;
    assign lit = lit3_reg;
    assign pixel_hue = hue3_reg;
    assign pixel_sat = sat3_reg;
    assign pixel_bright = bri3_reg;
endmodule

// File: hdl/lcpr_checker.sv
// ----------------------------------------------------------------------------
// lcpr_checker: port-level checks of the comet pool renderer
// Handshake and result consistency seen at the top level ports.
// ----------------------------------------------------------------------------
module lcpr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
    a_unlit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[23:0] == 24'd0) else $error("unlit has color");
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("request taken with result pending");
    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[25:24] == 2'd0) else $error("lit start");
endmodule

bind led_comet_pool_renderer lcpr_checker u_lcpr_checker (.aclk, .aresetn, .s_tvalid,
    .s_tready, .m_tvalid, .m_tready, .m_tdata, .m_tuser);

// File: sim/led_comet_pool_renderer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// led_comet_pool_renderer_test: self-checking bench for the comet pool
// Drives start, advance, query and unused-kind requests through several register
// settings and checks every result against an in-bench slot pool model.
// ----------------------------------------------------------------------------
module led_comet_pool_renderer_test;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE = 40;
    localparam int PHASE_ITEMS = 175;

    // one expected answer on the result side
    typedef struct packed {
        logic       lit;
        logic [7:0] hue;
        logic [7:0] sat;
        logic [7:0] bright;
        logic [1:0] started;
    } pixel_ans_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    led_comet_pool_renderer dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // shadow of the block's registers
    logic [15:0] interval_ms;
    logic [3:0]  step;
    logic [5:0]  tail;
    logic [9:0]  strip_len;
    logic [7:0]  sat_base, sat_loss, bri_base, bri_loss;

    // shadow slot pool
    logic        pool_on   [lcpr_pkg::SLOTS];
    int          pool_head [lcpr_pkg::SLOTS];
    logic [9:0]  pool_org  [lcpr_pkg::SLOTS];
    logic        pool_back [lcpr_pkg::SLOTS];
    logic [7:0]  pool_hue  [lcpr_pkg::SLOTS];
    logic [31:0] pool_last [lcpr_pkg::SLOTS];

    logic [57:0] pending_reqs[$];   // requests not yet offered: {kind, tdata}
    pixel_ans_t  pixel_answers[$];  // answers still to arrive
    int          errors;
    int          cycles;
    logic        no_idle;           // stretch with no gaps on either side
    int          hold_ask, hold_seen, hold_left;
    int          send_gap, recv_gap;
    logic [31:0] tm;                // running time cursor for well-formed sequences

    task automatic report(input string what);
        $display("MISMATCH at cycle %0d: %s", cycles, what);
        errors++;
    endtask

    function automatic logic [7:0] tail_jitter(logic [7:0] h, logic [9:0] o, int k);
        logic [31:0] v;
        v = 32'(h) * 32'd47 + 32'(o) * 32'd13 + 32'(k) * 32'd29;
        v = v ^ (v >> 8);
        v = v * 32'd199873;
        return v[7:0];
    endfunction

    // apply one request to the shadow pool and queue its answer
    task automatic predict_pixel(input logic [57:0] d);
        lcpr_pkg::kind_t kd;
        logic [31:0] now;
        logic [9:0]  pos;
        logic [7:0]  h, n;
        pixel_ans_t  a;
        int          k, x, s, pass;
        kd  = lcpr_pkg::kind_t'(d[57:56]);
        now = d[31:0];
        pos = d[41:32];
        h   = d[49:42];
        a   = '0;
        case (kd)
            lcpr_pkg::KIND_START: begin
                for (pass = 0; pass < 2; pass++) begin
                    for (s = 0; s < lcpr_pkg::SLOTS; s++) begin
                        if (!pool_on[s]) begin
                            pool_on[s] = 1'b1;
                            pool_head[s] = pos;
                            pool_org[s] = pos;
                            pool_back[s] = (pass == 0);
                            pool_hue[s] = h;
                            pool_last[s] = now;
                            a.started++;
                            break;
                        end
                    end
                end
            end
            lcpr_pkg::KIND_ADVANCE: begin
                for (s = 0; s < lcpr_pkg::SLOTS; s++) begin
                    if (pool_on[s] && (now - pool_last[s]) >= 32'(interval_ms)) begin
                        pool_last[s] = now;
                        x = pool_back[s] ? pool_head[s] - int'(step) : pool_head[s] + int'(step);
                        if (x < 0 || x >= int'(strip_len)) begin
                            pool_on[s] = 1'b0;
                            pool_head[s] = 0;
                        end else begin
                            pool_head[s] = x;
                        end
                    end
                end
            end
            lcpr_pkg::KIND_QUERY: begin
                if (pos < strip_len) begin
                    for (s = 0; s < lcpr_pkg::SLOTS; s++) begin
                        if (!pool_on[s]) continue;
                        k = pool_back[s] ? int'(pos) - pool_head[s] : pool_head[s] - int'(pos);
                        if (k < 0 || k >= int'(tail)) continue;
                        n = tail_jitter(pool_hue[s], pool_org[s], k);
                        a.lit = 1'b1;
                        a.hue = pool_hue[s];
                        x = int'(sat_base) - k * int'(sat_loss) - int'(n & 8'h1F);
                        a.sat = (x < 20) ? 8'd20 : (x > 255) ? 8'd255 : 8'(x);
                        x = int'(bri_base) - k * int'(bri_loss) - int'(n & 8'h3F);
                        a.bright = (x < 0) ? 8'd0 : (x > 255) ? 8'd255 : 8'(x);
                    end
                end
            end
            default: ;  // unused kind: nothing changes, all zero
        endcase
        pixel_answers.push_back(a);
    endtask

    function automatic logic [57:0] pack_req(lcpr_pkg::kind_t kd, logic [31:0] now,
                                             logic [9:0] pos, logic [7:0] h);
        return {kd, 6'd0, h, pos, now};
    endfunction

    // ------------------------------------------------------------------
    // clock, cycle counter and timeout
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // request driver: pops pending_reqs, random gap after each request,
    // valid stays high across back-to-back requests
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        int g;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else if (s_tvalid && s_tready) begin
            predict_pixel({s_tuser, s_tdata});
            g = no_idle ? 0 : $urandom_range(0, 7);
            if (g == 0 && pending_reqs.size() > 0) begin
                {s_tuser, s_tdata} <= pending_reqs.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
            send_gap <= g;
        end else if (!s_tvalid) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
            end else if (pending_reqs.size() > 0) begin
                {s_tuser, s_tdata} <= pending_reqs.pop_front();
                s_tvalid <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor: checks each result, random back-pressure, and a
    // long hold-off whenever hold_ask is bumped
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        pixel_ans_t a;
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_gap <= 0;
            hold_left <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pixel_answers.size() == 0) begin
                    report("result with no request outstanding");
                end else begin
                    a = pixel_answers.pop_front();
                    if (m_tuser !== a.lit)
                        report($sformatf("lit %b, want %b", m_tuser, a.lit));
                    if (m_tdata[7:0] !== a.hue)
                        report($sformatf("hue %0d, want %0d", m_tdata[7:0], a.hue));
                    if (m_tdata[15:8] !== a.sat)
                        report($sformatf("saturation %0d, want %0d", m_tdata[15:8], a.sat));
                    if (m_tdata[23:16] !== a.bright)
                        report($sformatf("brightness %0d, want %0d",
                                         m_tdata[23:16], a.bright));
                    if (m_tdata[25:24] !== a.started)
                        report($sformatf("started %0d, want %0d",
                                         m_tdata[25:24], a.started));
                end
            end
            if (hold_ask != hold_seen) begin
                hold_seen <= hold_ask;
                hold_left <= 400;
                m_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready <= (hold_left == 1);
            end else if (m_tvalid && m_tready) begin
                recv_gap <= no_idle ? 0 : $urandom_range(0, 7);
                m_tready <= no_idle;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_tready <= (recv_gap == 1);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // sequencing helpers
    // ------------------------------------------------------------------
    task automatic wait_drained();
        while (pending_reqs.size() > 0 || s_tvalid || pixel_answers.size() > 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input lcpr_pkg::reg_idx_t idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            lcpr_pkg::REG_MOVE_INTERVAL: interval_ms = val;
            lcpr_pkg::REG_STEP_SIZE:     step = val[3:0];
            lcpr_pkg::REG_TAIL_LENGTH:   tail = val[5:0];
            lcpr_pkg::REG_LED_COUNT:     strip_len = val[9:0];
            lcpr_pkg::REG_BASE_SAT:      sat_base = val[7:0];
            lcpr_pkg::REG_SAT_DECAY:     sat_loss = val[7:0];
            lcpr_pkg::REG_BASE_BRIGHT:   bri_base = val[7:0];
            default:                     bri_loss = val[7:0];
        endcase
    endtask

    task automatic write_all(input logic [15:0] iv, input logic [3:0] st,
                             input logic [5:0] tl, input logic [9:0] lc,
                             input logic [7:0] bs, input logic [7:0] sd,
                             input logic [7:0] bb, input logic [7:0] bd);
        write_reg(lcpr_pkg::REG_MOVE_INTERVAL, iv);
        write_reg(lcpr_pkg::REG_STEP_SIZE, 16'(st));
        write_reg(lcpr_pkg::REG_TAIL_LENGTH, 16'(tl));
        write_reg(lcpr_pkg::REG_LED_COUNT, 16'(lc));
        write_reg(lcpr_pkg::REG_BASE_SAT, 16'(bs));
        write_reg(lcpr_pkg::REG_SAT_DECAY, 16'(sd));
        write_reg(lcpr_pkg::REG_BASE_BRIGHT, 16'(bb));
        write_reg(lcpr_pkg::REG_BRIGHT_DECAY, 16'(bd));
    endtask

    // mostly well-formed traffic: time moves forward, queries land on the
    // strip; a few requests use wild times, off-strip positions or kind 3
    task automatic queue_random(input int count);
        int r, i;
        logic [9:0] pos;
        for (i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                pending_reqs.push_back(pack_req(lcpr_pkg::KIND_NONE, $urandom,
                                                10'($urandom), 8'($urandom)));
            end else if (r < 23) begin
                pos = ($urandom_range(0, 9) == 0 || strip_len == 0) ? 10'($urandom)
                      : 10'($urandom_range(0, strip_len - 1));
                pending_reqs.push_back(pack_req(lcpr_pkg::KIND_START, tm, pos,
                                                8'($urandom)));
            end else if (r < 53) begin
                if ($urandom_range(0, 29) == 0)
                    tm = $urandom;
                else
                    tm = tm + $urandom_range(0, 2 * int'(interval_ms) + 2);
                pending_reqs.push_back(pack_req(lcpr_pkg::KIND_ADVANCE, tm,
                                                10'($urandom), 8'($urandom)));
            end else begin
                pos = ($urandom_range(0, 9) == 0 || strip_len == 0) ? 10'($urandom)
                      : 10'($urandom_range(0, strip_len - 1));
                pending_reqs.push_back(pack_req(lcpr_pkg::KIND_QUERY, $urandom, pos,
                                                8'($urandom)));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        int ph, s;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = lcpr_pkg::REG_MOVE_INTERVAL;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = lcpr_pkg::KIND_START;
        m_tready = 1'b0;
        errors = 0;
        cycles = 0;
        no_idle = 1'b0;
        hold_ask = 0;
        hold_seen = 0;
        interval_ms = 16'd20; step = 4'd3; tail = 6'd20; strip_len = 10'd960;
        sat_base = 8'd220; sat_loss = 8'd10; bri_base = 8'd255; bri_loss = 8'd18;
        for (s = 0; s < lcpr_pkg::SLOTS; s++) begin
            pool_on[s] = 1'b0;
            pool_head[s] = 0;
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset defaults, edges of the strip, pool full, wrap, kind 3
        tm = 32'hFFFF_FFF0;
        pending_reqs.push_back(pack_req(lcpr_pkg::KIND_QUERY, 32'h0, 10'd0, 8'h00));
        pending_reqs.push_back(pack_req(lcpr_pkg::KIND_START, tm, 10'd0, 8'h00));
        pending_reqs.push_back(pack_req(lcpr_pkg::KIND_START, tm, 10'd959, 8'hFF));
        pending_reqs.push_back(pack_req(lcpr_pkg::KIND_START, tm, 10'd1023, 8'hA5)); // off strip
        pending_reqs.push_back(pack_req(lcpr_pkg::KIND_START, tm, 10'd500, 8'h5A));
        pending_reqs.push_back(pack_req(lcpr_pkg::KIND_START, tm, 10'd510, 8'h3C));
        pending_reqs.push_back(pack_req(lcpr_pkg::KIND_START, tm, 10'd520, 8'hC3));
        pending_reqs.push_back(pack_req(lcpr_pkg::KIND_START, tm, 10'd530, 8'h11)); // pool full
        pending_reqs.push_back(pack_req(lcpr_pkg::KIND_QUERY, 32'hFFFF_FFFF, 10'd0, 8'hFF));
        pending_reqs.push_back(pack_req(lcpr_pkg::KIND_QUERY, 32'h0, 10'd959, 8'h00));
        pending_reqs.push_back(pack_req(lcpr_pkg::KIND_QUERY, 32'h0, 10'd960, 8'h00)); // off strip
        pending_reqs.push_back(pack_req(lcpr_pkg::KIND_QUERY, 32'h0, 10'd1023, 8'h00));
        pending_reqs.push_back(pack_req(lcpr_pkg::KIND_QUERY, 32'h0, 10'd505, 8'h00));
        pending_reqs.push_back(pack_req(lcpr_pkg::KIND_ADVANCE, 32'hFFFF_FFF5, 10'd0, 8'h00));
        pending_reqs.push_back(pack_req(lcpr_pkg::KIND_ADVANCE, 32'h0000_0004, 10'd0, 8'h00));
        pending_reqs.push_back(pack_req(lcpr_pkg::KIND_ADVANCE, 32'h0000_0018, 10'h3FF, 8'hFF));
        pending_reqs.push_back(pack_req(lcpr_pkg::KIND_QUERY, 32'h0, 10'd956, 8'h00));
        pending_reqs.push_back(pack_req(lcpr_pkg::KIND_QUERY, 32'h0, 10'd3, 8'h00));
        pending_reqs.push_back(pack_req(lcpr_pkg::KIND_START, 32'h0000_0018, 10'd700, 8'h77));
        pending_reqs.push_back(pack_req(lcpr_pkg::KIND_NONE, 32'hFFFF_FFFF, 10'h3FF, 8'hFF));
        pending_reqs.push_back(pack_req(lcpr_pkg::KIND_QUERY, 32'h0, 10'd700, 8'h00));
        tm = 32'h0000_0018;
        wait_drained();

        for (ph = 0; ph < 8; ph++) begin
            case (ph)
                0: write_all(16'd0, 4'd1, 6'd32, 10'd40, 8'd255, 8'd0, 8'd255, 8'd0);
                1: write_all(16'd65535, 4'd15, 6'd1, 10'd1023, 8'd0, 8'd255, 8'd0, 8'd255);
                2: write_all(16'd5, 4'd0, 6'd63, 10'd30, 8'd200, 8'd3, 8'd128, 8'd4);
                3: write_all(16'd3, 4'd2, 6'd0, 10'd0, 8'd100, 8'd1, 8'd100, 8'd1);
                default: write_all(16'($urandom_range(0, 40)), 4'($urandom_range(0, 15)),
                                   6'($urandom_range(0, 63)), 10'($urandom_range(8, 160)),
                                   8'($urandom), 8'($urandom_range(0, 20)),
                                   8'($urandom), 8'($urandom_range(0, 20)));
            endcase
            no_idle = (ph == 5);
            queue_random(PHASE_ITEMS);
            if (ph == 0) begin
                // receiver stalls long while the sender keeps offering
                repeat (30) @(posedge aclk);
                hold_ask = hold_ask + 1;
            end
            wait_drained();
            if (ph == 1) begin
                // narrow the strip while comets are still live
                write_reg(lcpr_pkg::REG_LED_COUNT, 16'd10);
                queue_random(20);
                wait_drained();
            end
        end

        if (errors == 0 && pixel_answers.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/lcpr_pkg.sv
hdl/lcpr_cell.sv
hdl/lcpr_shade.sv
hdl/led_comet_pool_renderer.sv
hdl/lcpr_checker.sv
sim/led_comet_pool_renderer_test.sv
